// ----- src/ncpf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncpf_pkg
// Shared types and constants of the NC program flow controller.
// ----------------------------------------------------------------------------
package ncpf_pkg;

  localparam int ProgNumBits = 17;
  localparam int LineAddrBits = 24;
  localparam int MCodeBits = 8;
  localparam int LValueBits = 14;
  localparam int RepeatBits = 15;
  localparam int StatusBits = 3;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_LINE_END = 1'b1;

  localparam logic [MCodeBits-1:0] M_NEXT_PROG = 8'd30;
  localparam logic [MCodeBits-1:0] M_CALL = 8'd98;
  localparam logic [MCodeBits-1:0] M_RETURN = 8'd99;

  localparam logic [StatusBits-1:0] ST_CONTINUE = 3'd0;
  localparam logic [StatusBits-1:0] ST_JUMP = 3'd1;
  localparam logic [StatusBits-1:0] ST_END = 3'd2;
  localparam logic [StatusBits-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [StatusBits-1:0] ST_FULL = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_POP,
    S_RESULT
  } ncpf_state_e;

endpackage

// ----- src/ncpf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncpf_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ncpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/nc_program_flow_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nc_program_flow_controller
// Next-line address logic of a G-code interpreter with an M98/M99 call stack.
// ----------------------------------------------------------------------------
// One word in, one word out. A register word, an M99 or a line with any other
// M code passes from decode, through a stack pop for an M99 on a non-empty
// stack, to the result. M30 and M98 walk the program table through the read
// port of the table RAM, one entry per cycle, up to the result. The input is
// stalled while a word is in work; a finished result sits in an output
// register, so the next word is taken while it waits. Table and stack
// live in RAMs with no reset and need no clearing pass: only entries below the
// fill count and the stack depth are ever read.
// ----------------------------------------------------------------------------
module nc_program_flow_controller
  import ncpf_pkg::*;
#(
  parameter int PROGRAM_SLOTS = 64,
  parameter int STACK_SLOTS = 32,
  parameter int ADDRESS_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic [ProgNumBits-1:0]  program_number_i,
  input  logic [LineAddrBits-1:0] line_address_i,
  input  logic signed [MCodeBits-1:0] m_code_i,
  input  logic [ProgNumBits-1:0]  p_value_i,
  input  logic                    l_present_i,
  input  logic [LValueBits-1:0]   l_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [LineAddrBits-1:0] next_address_o,
  output logic [StatusBits-1:0]   status_o
);

  localparam int AW = ADDRESS_BITS;
  localparam int TAW = PROGRAM_SLOTS > 1 ? $clog2(PROGRAM_SLOTS) : 1;
  localparam int TIW = $clog2(PROGRAM_SLOTS + 1);
  localparam int SAW = STACK_SLOTS > 1 ? $clog2(STACK_SLOTS) : 1;
  localparam int SIW = $clog2(STACK_SLOTS + 1);
  localparam int TW = 1 + ProgNumBits + AW;
  localparam int SW = 2 * AW + RepeatBits;

  ncpf_state_e state_q, state_d;

  logic                   op_q;
  logic [ProgNumBits-1:0] prog_q;
  logic [AW-1:0]          addr_q;
  logic [MCodeBits-1:0]   m_q;
  logic [ProgNumBits-1:0] pval_q;
  logic                   lpres_q;
  logic [LValueBits-1:0]  lval_q;

  logic [TIW-1:0] idx_q, idx_d;
  logic           pend_q, pend_d;
  logic [TAW-1:0] pend_idx_q, pend_idx_d;
  logic [TIW-1:0] tcount_q, tcount_d;
  logic [SIW-1:0] depth_q, depth_d;
  logic [LValueBits-1:0] repeat_q, repeat_d;

  logic [AW-1:0]         res_addr_q, res_addr_d;
  logic [StatusBits-1:0] res_status_q, res_status_d;

  logic                    out_valid_q, out_valid_d;
  logic [LineAddrBits-1:0] out_addr_q;
  logic [StatusBits-1:0]   out_status_q;

  logic           t_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [TW-1:0]  t_wdata, t_rdata;
  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [SW-1:0]  s_wdata, s_rdata;

  logic                   in_accept, out_load;
  logic                   t_exec;
  logic [ProgNumBits-1:0] t_prog;
  logic [AW-1:0]          t_start;
  logic [AW-1:0]          s_target, s_return;
  logic [RepeatBits-1:0]  s_rep;
  logic                   is_m30, is_m98, is_m99;
  logic                   entry_match, hit, scan_end, issue;
  logic                   table_full, stack_full;
  logic [SAW-1:0]         top_idx;

  ncpf_ram #(.WIDTH(TW), .DEPTH(PROGRAM_SLOTS)) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  ncpf_ram #(.WIDTH(SW), .DEPTH(STACK_SLOTS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);

  assign t_exec = t_rdata[TW-1];
  assign t_prog = t_rdata[AW+ProgNumBits-1:AW];
  assign t_start = t_rdata[AW-1:0];
  assign s_target = s_rdata[SW-1:AW+RepeatBits];
  assign s_return = s_rdata[AW+RepeatBits-1:RepeatBits];
  assign s_rep = s_rdata[RepeatBits-1:0];

  assign is_m30 = (m_q == M_NEXT_PROG);
  assign is_m98 = (m_q == M_CALL);
  assign is_m99 = (m_q == M_RETURN);

  assign entry_match = is_m30 ? ((t_start > addr_q) && !t_exec) : (t_prog == pval_q);
  assign hit = pend_q && entry_match;
  assign issue = (idx_q < tcount_q);
  assign scan_end = !pend_q && !issue;
  assign table_full = (tcount_q >= TIW'(PROGRAM_SLOTS));
  assign stack_full = (depth_q >= SIW'(STACK_SLOTS));
  assign top_idx = SAW'(depth_q - SIW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (op_q == OP_LINE_END && (is_m30 || is_m98)) begin
          state_d = S_SCAN;
        end else if (op_q == OP_LINE_END && is_m99 && depth_q != '0) begin
          state_d = S_POP;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SCAN: begin
        if (hit || scan_end) begin
          state_d = S_RESULT;
        end
      end
      S_POP: state_d = S_RESULT;
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    idx_d = idx_q;
    pend_d = pend_q;
    pend_idx_d = pend_idx_q;
    tcount_d = tcount_q;
    depth_d = depth_q;
    repeat_d = repeat_q;
    res_addr_d = res_addr_q;
    res_status_d = res_status_q;
    t_we = 1'b0;
    t_waddr = pend_idx_q;
    t_wdata = {1'b1, t_prog, t_start};
    t_raddr = idx_q[TAW-1:0];
    s_we = 1'b0;
    s_waddr = top_idx;
    s_wdata = {s_target, s_return, s_rep - RepeatBits'(1)};
    s_raddr = top_idx;
    case (state_q)
      S_DECODE: begin
        idx_d = '0;
        pend_d = 1'b0;
        res_addr_d = addr_q;
        res_status_d = ST_CONTINUE;
        if (op_q == OP_REGISTER) begin
          if (table_full) begin
            res_status_d = ST_FULL;
          end else begin
            t_we = 1'b1;
            t_waddr = tcount_q[TAW-1:0];
            t_wdata = {1'b0, prog_q, addr_q};
            tcount_d = tcount_q + TIW'(1);
          end
        end else begin
          if (lpres_q) begin
            repeat_d = lval_q;
          end
          if (is_m99 && depth_q == '0) begin
            res_addr_d = '0;
            res_status_d = ST_END;
          end
        end
      end
      S_SCAN: begin
        pend_d = issue;
        pend_idx_d = idx_q[TAW-1:0];
        if (issue) begin
          idx_d = idx_q + TIW'(1);
        end
        if (hit) begin
          pend_d = 1'b0;
          if (is_m30) begin
            t_we = 1'b1;
            res_addr_d = t_start;
            res_status_d = ST_JUMP;
          end else if (stack_full) begin
            res_addr_d = addr_q;
            res_status_d = ST_OVERFLOW;
          end else begin
            t_we = 1'b1;
            s_we = 1'b1;
            s_waddr = depth_q[SAW-1:0];
            s_wdata = {t_start, addr_q, RepeatBits'(repeat_q)};
            depth_d = depth_q + SIW'(1);
            repeat_d = LValueBits'(1);
            res_addr_d = t_start;
            res_status_d = ST_JUMP;
          end
        end else if (scan_end) begin
          if (is_m30) begin
            res_addr_d = '0;
            res_status_d = ST_END;
          end else begin
            res_addr_d = addr_q;
            res_status_d = ST_CONTINUE;
          end
        end
      end
      S_POP: begin
        res_status_d = ST_JUMP;
        if (s_rep > RepeatBits'(1)) begin
          s_we = 1'b1;
          res_addr_d = s_target;
        end else begin
          depth_d = depth_q - SIW'(1);
          res_addr_d = s_return;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      pend_q <= 1'b0;
      tcount_q <= '0;
      depth_q <= '0;
      repeat_q <= LValueBits'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      pend_q <= pend_d;
      tcount_q <= tcount_d;
      depth_q <= depth_d;
      repeat_q <= repeat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q <= operation_i;
      prog_q <= program_number_i;
      addr_q <= AW'(line_address_i);
      m_q <= m_code_i;
      pval_q <= p_value_i;
      lpres_q <= l_present_i;
      lval_q <= l_value_i;
    end
    pend_idx_q <= pend_idx_d;
    res_addr_q <= res_addr_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_addr_q <= LineAddrBits'(res_addr_q);
      out_status_q <= res_status_q;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign next_address_o = out_addr_q;
  assign status_o = out_status_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= SIW'(STACK_SLOTS))
    else $error("stack depth beyond capacity");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tcount_q <= TIW'(PROGRAM_SLOTS))
    else $error("table count beyond capacity");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_we && state_q == S_SCAN) |-> !stack_full)
    else $error("push into a full stack");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESULT))
    else $error("result word without a finished item");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (in_stall_o && !$stable(state_q)))
    else $error("accepted word not taken into work");

endmodule
